@@ design/bei_pkg.sv @@
// shared types and constants for the breakpoint envelope interpolator
`default_nettype none
package bei_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int STAMP_W = 31;
   localparam int LEVEL_W = 32;
   localparam int COUNT_W = 7;
   localparam int SLOT_W = 6;
   localparam int DIFF_W = 33;
   localparam int PROD_W = 64;
   localparam int QUO_W = 33;
   localparam int DIV_CNT_W = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_POINTS = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENDS_RD,
      ST_ENDS_EV,
      ST_WALK_RD0,
      ST_WALK_EV0,
      ST_WALK_RDF,
      ST_WALK_EVF,
      ST_WALK_RDB,
      ST_WALK_EVB,
      ST_MUL_PREP,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINAL,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_A,
      RES_B,
      RES_CALC
   } res_sel_type;

   typedef struct packed {
      logic        accept_write;
      logic        accept_query;
      logic        sel_ends;
      logic        idx_start;
      logic        idx_inc;
      logic        idx_dec;
      logic        seg_zero;
      logic        seg_last;
      logic        seg_idx;
      logic        res_load;
      res_sel_type res_sel;
      logic        prep;
      logic        mul;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic size_zero;
      logic size_lt2;
      logic t_neg;
      logic t_ge_b;
      logic t_gt_b;
      logic back_more;
      logic span_bad;
      logic div_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ design/breakpoint_envelope_interpolate_core.sv @@
// top level of the breakpoint envelope interpolator
// a write request is taken in the idle state and gives no response
// a query on an empty or short table, before time zero or at or past the last stamp goes
// to the result state straight after the end check; an interpolating query first walks
// segment steps from the cached segment and runs the 33-step shift-subtract divider; the
// next request is taken in the cycle after the response is loaded
// reset clears the state machine, point count, cached segment and response valid; the
// table itself is not cleared and holds what was last written
`default_nettype none
module breakpoint_envelope_interpolate_core #(
   parameter int MAX_POINTS = bei_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic [bei_pkg::SLOT_W-1:0]         req_point_slot,
   input  wire logic [bei_pkg::STAMP_W-1:0]        req_point_stamp,
   input  wire logic signed [bei_pkg::LEVEL_W-1:0] req_point_level,
   input  wire logic signed [bei_pkg::LEVEL_W-1:0] req_query_stamp,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [bei_pkg::LEVEL_W-1:0]      rsp_level_out,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bei_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [bei_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bei_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import bei_pkg::*;

   cmd_type    cmd;
   status_type st;

   bei_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .st         (st),
      .cmd        (cmd)
   );

   bei_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_point_slot  (req_point_slot),
      .req_point_stamp (req_point_stamp),
      .req_point_level (req_point_level),
      .req_query_stamp (req_query_stamp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_level_out   (rsp_level_out),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata)
   );

   assign csr_pready = 1'b1;

endmodule
`default_nettype wire

@@ design/bei_datapath.sv @@
// breakpoint table, segment walk registers, multiplier, divider and result register
`default_nettype none
module bei_datapath #(
   parameter int MAX_POINTS = bei_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bei_pkg::cmd_type                  cmd,
   output bei_pkg::status_type                    st,
   input  wire logic [bei_pkg::SLOT_W-1:0]        req_point_slot,
   input  wire logic [bei_pkg::STAMP_W-1:0]       req_point_stamp,
   input  wire logic signed [bei_pkg::LEVEL_W-1:0] req_point_level,
   input  wire logic signed [bei_pkg::LEVEL_W-1:0] req_query_stamp,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [bei_pkg::LEVEL_W-1:0]     rsp_level_out,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bei_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [bei_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bei_pkg::CSR_DATA_W-1:0]         csr_prdata
);
   import bei_pkg::*;

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SW = $clog2(MAX_POINTS + 1);
   localparam int CW = (SW > COUNT_W) ? SW : COUNT_W;

   logic [STAMP_W-1:0] times_mem [MAX_POINTS];
   logic [LEVEL_W-1:0] values_mem [MAX_POINTS];

   logic [COUNT_W-1:0]        num_points_ff;
   logic [IW-1:0]             seg_ff, seg_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic signed [LEVEL_W-1:0] t_ff;
   logic [STAMP_W-1:0]        ta_ff, tb_ff;
   logic signed [LEVEL_W-1:0] va_ff, vb_ff;
   logic                      neg_ff;
   logic [DIFF_W-1:0]         mag_ff;
   logic [STAMP_W-1:0]        off_ff, span_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [STAMP_W:0]          rem_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic signed [LEVEL_W-1:0] res_ff, res_in;
   logic                      rsp_valid_ff;
   logic signed [LEVEL_W-1:0] rsp_level_ff;

   logic [SW-1:0]             size;
   logic [IW-1:0]             addr_a, addr_b, start;
   logic signed [LEVEL_W:0]   t_ext, ta_ext, tb_ext, off_raw;
   logic signed [LEVEL_W-1:0] span_raw;
   logic signed [DIFF_W-1:0]  diff;
   logic [STAMP_W:0]          trial;
   logic signed [DIFF_W:0]    calc;

   always_comb begin
      if (CW'(num_points_ff) > CW'(MAX_POINTS)) begin
         size = SW'(MAX_POINTS);
      end else begin
         size = SW'(num_points_ff);
      end
      start = (SW'(seg_ff) > size - SW'(2)) ? IW'(size - SW'(2)) : seg_ff;
      addr_a = cmd.sel_ends ? '0 : idx_ff;
      addr_b = cmd.sel_ends ? IW'(size - SW'(1)) : idx_ff + IW'(1);
      t_ext = {t_ff[LEVEL_W-1], t_ff};
      ta_ext = {2'b00, ta_ff};
      tb_ext = {2'b00, tb_ff};
      span_raw = {1'b0, tb_ff} - {1'b0, ta_ff};
      off_raw = t_ext - ta_ext;
      diff = {vb_ff[LEVEL_W-1], vb_ff} - {va_ff[LEVEL_W-1], va_ff};
      trial = {rem_ff[STAMP_W-1:0], quo_ff[QUO_W-1]};
      calc = {{2{va_ff[LEVEL_W-1]}}, va_ff}
             + (neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff}));
   end

   always_comb begin
      st.size_zero = (size == '0);
      st.size_lt2 = (size < SW'(2));
      st.t_neg = t_ff[LEVEL_W-1];
      st.t_ge_b = (t_ext >= tb_ext);
      st.t_gt_b = (t_ext > tb_ext);
      st.back_more = (idx_ff != '0) && (t_ext < ta_ext);
      st.span_bad = (span_raw <= 0);
      st.div_last = (cnt_ff == '0);
      st.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_start) begin
         idx_in = start;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IW'(1);
      end
      seg_in = seg_ff;
      if (cmd.seg_zero) begin
         seg_in = '0;
      end else if (cmd.seg_last) begin
         seg_in = IW'(size - SW'(2));
      end else if (cmd.seg_idx) begin
         seg_in = idx_ff;
      end
      case (cmd.res_sel)
         RES_ZERO: res_in = '0;
         RES_A:    res_in = va_ff;
         RES_B:    res_in = vb_ff;
         RES_CALC: res_in = calc[LEVEL_W-1:0];
         default:  res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= '0;
         seg_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_NUM_POINTS) begin
            num_points_ff <= csr_pwdata[COUNT_W-1:0];
         end
         seg_ff <= seg_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_write && ({26'd0, req_point_slot} < 32'(MAX_POINTS))) begin
         times_mem[IW'(req_point_slot)] <= req_point_stamp;
         values_mem[IW'(req_point_slot)] <= req_point_level;
      end
      ta_ff <= times_mem[addr_a];
      va_ff <= values_mem[addr_a];
      tb_ff <= times_mem[addr_b];
      vb_ff <= values_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         t_ff <= req_query_stamp;
      end
      idx_ff <= idx_in;
      if (cmd.prep) begin
         neg_ff <= diff[DIFF_W-1];
         mag_ff <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
         span_ff <= span_raw[STAMP_W-1:0];
         if (off_raw < 0) begin
            off_ff <= '0;
         end else if (off_raw > $signed({2'b00, span_raw[STAMP_W-1:0]})) begin
            off_ff <= span_raw[STAMP_W-1:0];
         end else begin
            off_ff <= off_raw[STAMP_W-1:0];
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mag_ff) * PROD_W'(off_ff);
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, prod_ff[PROD_W-1:QUO_W]};
         quo_ff <= prod_ff[QUO_W-1:0];
         cnt_ff <= DIV_CNT_W'(QUO_W - 1);
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, span_ff}) begin
            rem_ff <= trial - {1'b0, span_ff};
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.out_load) begin
         rsp_level_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level_out = rsp_level_ff;
   assign csr_prdata = (csr_paddr == CSR_NUM_POINTS) ?
                       CSR_DATA_W'(num_points_ff) : '0;

endmodule
`default_nettype wire

@@ design/bei_controller.sv @@
// sequencing state machine for writes, end checks, segment walk and division
`default_nettype none
module bei_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire bei_pkg::status_type st,
   output bei_pkg::cmd_type         cmd
);
   import bei_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_QUERY) begin
                  cmd.accept_query = 1'b1;
                  state_in = ST_ENDS_RD;
               end else begin
                  cmd.accept_write = 1'b1;
               end
            end
         end
         ST_ENDS_RD: begin
            cmd.sel_ends = 1'b1;
            state_in = ST_ENDS_EV;
         end
         ST_ENDS_EV: begin
            cmd.sel_ends = 1'b1;
            if (st.size_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel = RES_ZERO;
               cmd.seg_zero = 1'b1;
               state_in = ST_RESULT;
            end else if (st.size_lt2 || st.t_neg) begin
               cmd.res_load = 1'b1;
               cmd.res_sel = RES_A;
               cmd.seg_zero = 1'b1;
               state_in = ST_RESULT;
            end else if (st.t_ge_b) begin
               cmd.res_load = 1'b1;
               cmd.res_sel = RES_B;
               cmd.seg_last = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.idx_start = 1'b1;
               state_in = ST_WALK_RD0;
            end
         end
         ST_WALK_RD0: state_in = ST_WALK_EV0;
         ST_WALK_EV0: begin
            if (st.t_ge_b) begin
               cmd.idx_inc = 1'b1;
               state_in = ST_WALK_RDF;
            end else if (st.back_more) begin
               cmd.idx_dec = 1'b1;
               state_in = ST_WALK_RDB;
            end else begin
               state_in = ST_MUL_PREP;
            end
         end
         ST_WALK_RDF: state_in = ST_WALK_EVF;
         ST_WALK_EVF: begin
            if (st.t_gt_b) begin
               cmd.idx_inc = 1'b1;
               state_in = ST_WALK_RDF;
            end else begin
               state_in = ST_MUL_PREP;
            end
         end
         ST_WALK_RDB: state_in = ST_WALK_EVB;
         ST_WALK_EVB: begin
            if (st.back_more) begin
               cmd.idx_dec = 1'b1;
               state_in = ST_WALK_RDB;
            end else begin
               state_in = ST_MUL_PREP;
            end
         end
         ST_MUL_PREP: begin
            cmd.seg_idx = 1'b1;
            if (st.span_bad) begin
               cmd.res_load = 1'b1;
               cmd.res_sel = RES_B;
               state_in = ST_RESULT;
            end else begin
               cmd.prep = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.res_load = 1'b1;
            cmd.res_sel = RES_CALC;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_opcode == OP_QUERY) |=> state_ff == ST_ENDS_RD)
      else $error("query did not start the end check");
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && st.div_last) |=> state_ff == ST_FINAL)
      else $error("division did not finish");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && !st.out_free) |=> state_ff == ST_RESULT)
      else $error("result left while output busy");

endmodule
`default_nettype wire

@@ tb/breakpoint_envelope_interpolate_core_tb.sv @@
// self-checking testbench for the breakpoint envelope interpolator: table loads, queries, csr
`default_nettype none
module breakpoint_envelope_interpolate_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bei_pkg::*;

   typedef struct {
      logic                      opcode;
      logic [SLOT_W-1:0]         slot;
      logic [STAMP_W-1:0]        stamp;
      logic signed [LEVEL_W-1:0] level;
      logic signed [LEVEL_W-1:0] qstamp;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_WRITE;
   logic [SLOT_W-1:0] req_point_slot = '0;
   logic [STAMP_W-1:0] req_point_stamp = '0;
   logic signed [LEVEL_W-1:0] req_point_level = '0;
   logic signed [LEVEL_W-1:0] req_query_stamp = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [LEVEL_W-1:0] rsp_level_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   breakpoint_envelope_interpolate_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type pending_requests[$];
   logic signed [LEVEL_W-1:0] expected_levels[$];

   // predictor state
   logic [STAMP_W-1:0] table_stamp[MAX_POINTS_DEFAULT];
   logic signed [LEVEL_W-1:0] table_level[MAX_POINTS_DEFAULT];
   int cached_segment = 0;
   int point_count = 0;

   int errors = 0;
   int queries_checked = 0;
   int writes_taken = 0;
   int idle_mode = 0;
   int quiet_cycles = 0;
   logic req_fire_q = 1'b0;

   task automatic report(input string what, input logic signed [LEVEL_W-1:0] want,
                         input logic signed [LEVEL_W-1:0] got);
      $display("error: %s expected %h got %h at %0t", what, want, got, $realtime);
      errors++;
   endtask

   function automatic logic signed [LEVEL_W-1:0] envelope_level(
         input logic signed [LEVEL_W-1:0] q);
      int size;
      int idx;
      longint t, t0, t1, y0, y1, span, off, res;
      size = (point_count > MAX_POINTS_DEFAULT) ? MAX_POINTS_DEFAULT : point_count;
      t = q;
      if (size == 0) begin
         cached_segment = 0;
         res = 0;
      end else if (size < 2 || t < 0) begin
         cached_segment = 0;
         res = table_level[0];
      end else if (t >= longint'(table_stamp[size-1])) begin
         cached_segment = size - 2;
         res = table_level[size-1];
      end else begin
         idx = cached_segment;
         if (idx > size - 2) idx = size - 2;
         if (t >= longint'(table_stamp[idx+1])) begin
            idx++;
            while (t > longint'(table_stamp[idx+1])) idx++;
         end else begin
            while (idx > 0 && t < longint'(table_stamp[idx])) idx--;
         end
         cached_segment = idx;
         t0 = table_stamp[idx];
         t1 = table_stamp[idx+1];
         y0 = table_level[idx];
         y1 = table_level[idx+1];
         span = t1 - t0;
         if (span <= 0) begin
            res = y1;
         end else begin
            off = t - t0;
            if (off < 0) off = 0;
            if (off > span) off = span;
            res = y0 + ((y1 - y0) * off) / span;
         end
      end
      return res[LEVEL_W-1:0];
   endfunction

   function automatic bit idle_roll(input bit sender);
      int pct;
      case (idle_mode)
         0: pct = sender ? 18 : 64;
         1: pct = sender ? 64 : 18;
         default: pct = 0;
      endcase
      return $urandom_range(99) < pct;
   endfunction

   // driver
   always @(negedge clock) begin
      request_type r;
      if (!reset) begin
         rsp_ready <= !idle_roll(1'b0);
         if (!req_valid || req_fire_q) begin
            if (pending_requests.size() > 0 && !idle_roll(1'b1)) begin
               r = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_opcode <= r.opcode;
               req_point_slot <= r.slot;
               req_point_stamp <= r.stamp;
               req_point_level <= r.level;
               req_query_stamp <= r.qstamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      logic signed [LEVEL_W-1:0] want;
      req_fire_q <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_opcode == OP_WRITE) begin
               table_stamp[req_point_slot] = req_point_stamp;
               table_level[req_point_slot] = req_point_level;
               writes_taken++;
            end else begin
               expected_levels.push_back(envelope_level(req_query_stamp));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               report("unexpected response", '0, rsp_level_out);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_level_out !== want) report("level_out", want, rsp_level_out);
               queries_checked++;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 6000) begin
            $display("breakpoint_envelope_interpolate_core: mismatch");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input int value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == CSR_NUM_POINTS) point_count = value & 32'h7f;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_requests.size() == 0 && !req_valid && expected_levels.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   logic [STAMP_W-1:0] plan_stamp[MAX_POINTS_DEFAULT];

   task automatic push_write(input int slot, input logic [STAMP_W-1:0] stamp,
                             input logic signed [LEVEL_W-1:0] level);
      request_type r;
      r.opcode = OP_WRITE;
      r.slot = slot;
      r.stamp = stamp;
      r.level = level;
      r.qstamp = $urandom;
      plan_stamp[slot] = stamp;
      pending_requests.push_back(r);
   endtask

   task automatic push_query(input logic signed [LEVEL_W-1:0] q);
      request_type r;
      r.opcode = OP_QUERY;
      r.slot = $urandom;
      r.stamp = $urandom;
      r.level = $urandom;
      r.qstamp = q;
      pending_requests.push_back(r);
   endtask

   function automatic logic signed [LEVEL_W-1:0] random_level();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(2000)) - 1000;
         default: return $urandom;
      endcase
   endfunction

   // loads all 64 slots, kind 0 sorted small steps, 1 sorted big steps, 2 unordered
   task automatic load_table(input int kind);
      longint acc;
      longint step;
      acc = $urandom_range(kind == 1 ? 32'h0100_0000 : 32'h0000_4000);
      for (int i = 0; i < MAX_POINTS_DEFAULT; i++) begin
         if (kind == 2) acc = $urandom & 32'h7fffffff;
         push_write(i, acc[STAMP_W-1:0], random_level());
         case ($urandom_range(7))
            0: step = 0;
            1: step = $urandom_range(4);
            default: step = (kind == 1) ? $urandom_range(32'h0400_0000)
                                        : $urandom_range(32'h2_0000);
         endcase
         acc += step;
         if (acc > 32'h7fffffff) acc = 32'h7fffffff;
      end
   endtask

   function automatic logic signed [LEVEL_W-1:0] random_query(input int size);
      int k;
      longint a, b;
      if (size < 1) size = 1;
      if (size > MAX_POINTS_DEFAULT) size = MAX_POINTS_DEFAULT;
      k = $urandom_range(size - 1);
      case ($urandom_range(9))
         0: return $urandom;
         1: return -$signed({1'b0, $urandom_range(32'h7fffffff)}) - 1;
         2: return plan_stamp[k];
         3: return plan_stamp[size-1] + $urandom_range(1000);
         default: begin
            a = plan_stamp[k];
            b = (k + 1 < size) ? plan_stamp[k+1] : a + 100;
            if (b < a) b = a;
            a = a + {$urandom, $urandom} % (b - a + 1);
            if (a > 32'h7fffffff) a = 32'h7fffffff;
            return a[LEVEL_W-1:0];
         end
      endcase
   endfunction

   int setting_list[12] = '{0, 1, 2, 64, 127, 5, 64, 2, 33, 64, 3, 64};
   int table_kind[12] = '{0, 0, 1, 0, 1, 2, 1, 0, 2, 0, 1, 0};

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // empty table before anything is written
      csr_write(CSR_NUM_POINTS, 0);
      push_query(32'sh80000000);
      push_query(32'sh7fffffff);
      push_query(0);
      push_query(-1);
      drain();
      // writes to unused register addresses must leave the count alone
      csr_write(2'd1, 5);
      csr_write(2'd2, 7);
      csr_write(2'd3, 127);
      for (int p = 0; p < 12; p++) begin
         idle_mode = (p < 4) ? 0 : (p < 8) ? 1 : 2;
         load_table(table_kind[p]);
         drain();
         csr_write(CSR_NUM_POINTS, setting_list[p]);
         push_query(32'sh80000000);
         push_query(32'sh7fffffff);
         push_query(0);
         for (int i = 0; i < 62; i++) push_query(random_query(setting_list[p]));
         drain();
      end
      csr_write(CSR_NUM_POINTS, 64);
      drain();
      $display("covered %0d breakpoint writes and %0d checked queries", writes_taken,
               queries_checked);
      $display("count settings 0, 1, 2, 3, 5, 33, 64, 127; sorted, flat and unordered tables");
      if (errors == 0) begin
         $display("breakpoint_envelope_interpolate_core: match");
      end else begin
         $display("breakpoint_envelope_interpolate_core: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
